>>> sv/fcfs_pkg.sv
// fcfs_pkg: shared types and constants of the first-come-first-served timing block
// used by fcfs_cell, fcfs_div and fcfs_schedule_timing_top; no dependencies
package fcfs_pkg;

  localparam int unsigned FIELD_W = 16;  // id, arrival and burst width
  localparam int unsigned TIME_W  = 22;  // completion, turnaround, waiting
  localparam int unsigned TOTAL_W = 27;  // running sums
  localparam int unsigned AVG_W   = 30;  // averages, 8 fraction bits
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned DVD_W   = TOTAL_W + FRAC_W;  // divider dividend
  localparam int unsigned ITER_W  = 6;                 // holds DVD_W
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 176;

  typedef struct packed {
    logic [FIELD_W-1:0] bur;
    logic [FIELD_W-1:0] arr;
    logic [FIELD_W-1:0] id;
  } entry_t;

  // per-cycle command shared by every cell of the chain
  typedef struct packed {
    logic ins;  // insert the new beat at its sorted place
    logic pop;  // shift every entry one cell toward the head
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DIV_START,
    ST_DIV_WAIT
  } fsm_t;

endpackage

>>> sv/fcfs_cell.sv
// fcfs_cell: one sorting cell of the process chain, holds one entry
// ordered by (arrival, id); depends on fcfs_pkg
module fcfs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fcfs_pkg::cell_ctl_t ctl,
  input  fcfs_pkg::entry_t   new_ent,
  input  fcfs_pkg::entry_t   left_ent,
  input  logic               left_vld,
  input  logic               left_gt,
  input  fcfs_pkg::entry_t   right_ent,
  input  logic               right_vld,
  output fcfs_pkg::entry_t   ent,
  output logic               vld,
  output logic               gt
);

  fcfs_pkg::entry_t ent_r, ent_nxt;
  logic             vld_r, vld_nxt;

  // empty cells count as greater, so the new beat lands after all equal keys
  assign gt = !vld_r || ({ent_r.arr, ent_r.id} > {new_ent.arr, new_ent.id});

  always_comb begin
    ent_nxt = ent_r;
    vld_nxt = vld_r;
    if (ctl.ins && gt) begin
      if (left_gt) begin
        ent_nxt = left_ent;
        vld_nxt = left_vld;
      end else begin
        ent_nxt = new_ent;
        vld_nxt = 1'b1;
      end
    end else if (ctl.pop) begin
      ent_nxt = right_ent;
      vld_nxt = right_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
  assign vld = vld_r;

endmodule

>>> sv/fcfs_div.sv
// fcfs_div: two-lane restoring divider, one quotient bit per cycle,
// computes (total << 8) / count for both sums; depends on fcfs_pkg
module fcfs_div #(
  parameter int unsigned CW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fcfs_pkg::TOTAL_W-1:0] dvd_a,
  input  logic [fcfs_pkg::TOTAL_W-1:0] dvd_b,
  input  logic [CW-1:0]                dvs,
  output logic [fcfs_pkg::AVG_W-1:0]   quo_a,
  output logic [fcfs_pkg::AVG_W-1:0]   quo_b,
  output logic                         done
);

  localparam int unsigned DW = fcfs_pkg::DVD_W;

  logic [DW-1:0]                   qa_r, qa_nxt, qb_r, qb_nxt;
  logic [CW-1:0]                   ra_r, ra_nxt, rb_r, rb_nxt;
  logic [fcfs_pkg::ITER_W-1:0]     cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt, done_r, done_nxt;
  logic [CW:0]                     ta, tb;

  assign ta = {ra_r, qa_r[DW-1]};
  assign tb = {rb_r, qb_r[DW-1]};

  always_comb begin
    qa_nxt   = qa_r;
    qb_nxt   = qb_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      qa_nxt   = {dvd_a, {fcfs_pkg::FRAC_W{1'b0}}};
      qb_nxt   = {dvd_b, {fcfs_pkg::FRAC_W{1'b0}}};
      ra_nxt   = '0;
      rb_nxt   = '0;
      cnt_nxt  = fcfs_pkg::ITER_W'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ta >= {1'b0, dvs}) begin
        ra_nxt = CW'(ta - {1'b0, dvs});
        qa_nxt = {qa_r[DW-2:0], 1'b1};
      end else begin
        ra_nxt = CW'(ta);
        qa_nxt = {qa_r[DW-2:0], 1'b0};
      end
      if (tb >= {1'b0, dvs}) begin
        rb_nxt = CW'(tb - {1'b0, dvs});
        qb_nxt = {qb_r[DW-2:0], 1'b1};
      end else begin
        rb_nxt = CW'(tb);
        qb_nxt = {qb_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == fcfs_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qa_r <= qa_nxt;
    qb_r <= qb_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
  end

  assign quo_a = qa_r[fcfs_pkg::AVG_W-1:0];
  assign quo_b = qb_r[fcfs_pkg::AVG_W-1:0];
  assign done  = done_r;

endmodule

>>> sv/fcfs_schedule_timing_top.sv
// fcfs_schedule_timing_top: first-come-first-served schedule timing block
// built from a chain of fcfs_cell sorting cells and the fcfs_div divider;
// depends on fcfs_pkg
//
// usage:
//   in_*  : one beat per process, tdata = {burst, arrival, id}, tlast ends the set.
//           the beat that fills the store (MAX_PROCS entries) also ends the set.
//   out_* : one beat per process in schedule order (arrival, then id, stable);
//           tlast marks the final beat, which alone carries the two averages.
//   in_tready stays high while loading; each beat drops straight into its
//   sorted place in the cell chain, so no separate sort pass is needed.
//   after the last input beat the head cell is popped once per cycle, giving
//   N output beats back to back while the receiver keeps up; the last process
//   then waits on the shared divider through ST_DIV_START and ST_DIV_WAIT,
//   which forms one quotient bit per cycle, before the final beat shows.
//   in_tready is low from the last input beat until the final beat is shown.
//   a stalled receiver simply holds the output register and freezes the pop.
//   reset empties the cell chain and clears the fsm and the output valid.
module fcfs_schedule_timing_top #(
  parameter int unsigned MAX_PROCS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fcfs_pkg::IN_DATA_W-1:0]    in_tdata,   // proc_id, arrival, burst
  input  logic                              in_tlast,   // is_last
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_id, out_arrival, out_burst, completion, turnaround, waiting,
  // avg_turnaround_q8, avg_waiting_q8, zero pad
  output logic [fcfs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast   // last_result
);

  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned TW = fcfs_pkg::TIME_W;

  fcfs_pkg::fsm_t      state_r, state_nxt;
  fcfs_pkg::cell_ctl_t ctl;
  fcfs_pkg::entry_t    new_ent;
  fcfs_pkg::entry_t    cd [MAX_PROCS];
  logic [MAX_PROCS-1:0] cv, cg;

  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [TW-1:0]                 rc_r, rc_nxt;
  logic [fcfs_pkg::TOTAL_W-1:0]  tt_r, tt_nxt, wt_tot_r, wt_tot_nxt;

  // output register
  logic                          ov_r, ov_nxt, ol_r, ol_nxt;
  fcfs_pkg::entry_t              oe_r, oe_nxt;
  logic [TW-1:0]                 oc_r, oc_nxt, ot_r, ot_nxt, ow_r, ow_nxt;
  logic [fcfs_pkg::AVG_W-1:0]    oat_r, oat_nxt, oaw_r, oaw_nxt;

  logic                          in_acc, pop, head_last, div_start, div_done;
  logic [TW-1:0]                 start_t, comp_t, tat_t, wait_t;
  logic [fcfs_pkg::AVG_W-1:0]    avg_t, avg_w;

  assign in_acc  = in_tvalid && in_tready;
  assign new_ent = fcfs_pkg::entry_t'(in_tdata);
  // pop the head only when the output register is free or being drained
  assign pop     = (state_r == fcfs_pkg::ST_RUN) && (!ov_r || out_tready);
  assign ctl.ins = in_acc;
  assign ctl.pop = pop;

  // sorted chain: cell 0 is the head of the schedule
  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    fcfs_pkg::entry_t l_ent, r_ent;
    logic             l_vld, l_gt, r_vld;
    if (i == 0) begin : g_first
      assign l_ent = '0;
      assign l_vld = 1'b0;
      assign l_gt  = 1'b0;
    end else begin : g_mid_l
      assign l_ent = cd[i-1];
      assign l_vld = cv[i-1];
      assign l_gt  = cg[i-1];
    end
    if (i == MAX_PROCS - 1) begin : g_final
      assign r_ent = '0;
      assign r_vld = 1'b0;
    end else begin : g_mid_r
      assign r_ent = cd[i+1];
      assign r_vld = cv[i+1];
    end
    fcfs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .left_ent  (l_ent),
      .left_vld  (l_vld),
      .left_gt   (l_gt),
      .right_ent (r_ent),
      .right_vld (r_vld),
      .ent       (cd[i]),
      .vld       (cv[i]),
      .gt        (cg[i])
    );
  end

  // head is the final process when nothing waits behind it
  if (MAX_PROCS == 1) begin : g_one
    assign head_last = 1'b1;
  end else begin : g_many
    assign head_last = !cv[1];
  end

  // waiting = start - arrival, turnaround = waiting + burst
  assign start_t = (rc_r > TW'(cd[0].arr)) ? rc_r : TW'(cd[0].arr);
  assign comp_t  = start_t + TW'(cd[0].bur);
  assign wait_t  = start_t - TW'(cd[0].arr);
  assign tat_t   = wait_t + TW'(cd[0].bur);

  assign div_start = (state_r == fcfs_pkg::ST_DIV_START);

  fcfs_div #(.CW(CW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd_a (tt_r),
    .dvd_b (wt_tot_r),
    .dvs   (cnt_r),
    .quo_a (avg_t),
    .quo_b (avg_w),
    .done  (div_done)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rc_nxt     = rc_r;
    tt_nxt     = tt_r;
    wt_tot_nxt = wt_tot_r;
    ov_nxt     = ov_r && !out_tready;
    ol_nxt     = ol_r;
    oe_nxt     = oe_r;
    oc_nxt     = oc_r;
    ot_nxt     = ot_r;
    ow_nxt     = ow_r;
    oat_nxt    = oat_r;
    oaw_nxt    = oaw_r;
    in_tready  = 1'b0;
    unique case (state_r)
      fcfs_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_acc) begin
          cnt_nxt = cnt_r + 1'b1;
          if (in_tlast || cnt_r == CW'(MAX_PROCS - 1)) begin
            rc_nxt     = '0;
            tt_nxt     = '0;
            wt_tot_nxt = '0;
            state_nxt  = fcfs_pkg::ST_RUN;
          end
        end
      end
      fcfs_pkg::ST_RUN: begin
        if (pop) begin
          rc_nxt     = comp_t;
          tt_nxt     = tt_r + fcfs_pkg::TOTAL_W'(tat_t);
          wt_tot_nxt = wt_tot_r + fcfs_pkg::TOTAL_W'(wait_t);
          oe_nxt     = cd[0];
          oc_nxt     = comp_t;
          ot_nxt     = tat_t;
          ow_nxt     = wait_t;
          oat_nxt    = '0;
          oaw_nxt    = '0;
          ol_nxt     = 1'b0;
          if (head_last) begin
            // final process waits in the register until the averages are ready
            ov_nxt    = 1'b0;
            state_nxt = fcfs_pkg::ST_DIV_START;
          end else begin
            ov_nxt = 1'b1;
          end
        end
      end
      fcfs_pkg::ST_DIV_START: begin
        state_nxt = fcfs_pkg::ST_DIV_WAIT;
      end
      fcfs_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          oat_nxt   = avg_t;
          oaw_nxt   = avg_w;
          ol_nxt    = 1'b1;
          ov_nxt    = 1'b1;
          cnt_nxt   = '0;
          state_nxt = fcfs_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = fcfs_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fcfs_pkg::ST_LOAD;
      cnt_r    <= '0;
      rc_r     <= '0;
      tt_r     <= '0;
      wt_tot_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rc_r     <= rc_nxt;
      tt_r     <= tt_nxt;
      wt_tot_r <= wt_tot_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ol_r  <= ol_nxt;
    oe_r  <= oe_nxt;
    oc_r  <= oc_nxt;
    ot_r  <= ot_nxt;
    ow_r  <= ow_nxt;
    oat_r <= oat_nxt;
    oaw_r <= oaw_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {2'b00, oaw_r, oat_r, ow_r, ot_r, oc_r, oe_r.bur, oe_r.arr, oe_r.id};

  // no result beat is shown while the averages are being divided
  a_quiet_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcfs_pkg::ST_DIV_START || state_r == fcfs_pkg::ST_DIV_WAIT) |-> !ov_r)
    else $error("result beat shown during divide");

  // the chain never overflows: the last cell is empty whenever loading
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fcfs_pkg::ST_LOAD) |-> !cv[MAX_PROCS-1])
    else $error("cell chain full while loading");

  // every pop takes a real process from the head
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cv[0])
    else $error("pop from empty chain");

  // divider finishes only while the fsm waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == fcfs_pkg::ST_DIV_WAIT)
    else $error("divider done outside wait state");

endmodule

>>> verif/fcfs_timing_checker.sv
// fcfs_timing_checker: watches both stream channels of the fcfs schedule timing block,
// predicts the schedule of every loaded set and compares each output beat against it
// depends on fcfs_pkg for the field widths
module fcfs_timing_checker #(
  parameter int unsigned MAX_PROCS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [fcfs_pkg::IN_DATA_W-1:0]  in_tdata,   // proc_id, arrival, burst
  input  logic                            in_tlast,   // is_last
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // out_id, out_arrival, out_burst, completion, turnaround, waiting,
  // avg_turnaround_q8, avg_waiting_q8, zero pad
  input  logic [fcfs_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,  // last_result
  output int                              fail_count,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_W  = fcfs_pkg::FIELD_W;
  localparam int unsigned TIME_W   = fcfs_pkg::TIME_W;
  localparam int unsigned TOTAL_W  = fcfs_pkg::TOTAL_W;
  localparam int unsigned AVG_W    = fcfs_pkg::AVG_W;
  localparam int unsigned FRAC_W   = fcfs_pkg::FRAC_W;
  localparam int unsigned NFIELDS  = 9;
  localparam int unsigned ARR_LSB  = FIELD_W;
  localparam int unsigned BUR_LSB  = 2 * FIELD_W;
  localparam int unsigned COMP_LSB = 3 * FIELD_W;
  localparam int unsigned TAT_LSB  = COMP_LSB + TIME_W;
  localparam int unsigned WT_LSB   = TAT_LSB + TIME_W;
  localparam int unsigned AVGT_LSB = WT_LSB + TIME_W;
  localparam int unsigned AVGW_LSB = AVGT_LSB + AVG_W;

  typedef struct {
    bit [FIELD_W-1:0] id;
    bit [FIELD_W-1:0] arr;
    bit [FIELD_W-1:0] bur;
  } proc_rec_t;

  typedef struct {
    bit [FIELD_W-1:0] id;
    bit [FIELD_W-1:0] arr;
    bit [FIELD_W-1:0] bur;
    bit [TIME_W-1:0]  comp;
    bit [TIME_W-1:0]  tat;
    bit [TIME_W-1:0]  wt;
    bit [AVG_W-1:0]   avg_tat;
    bit [AVG_W-1:0]   avg_wt;
    bit               last;
  } sched_beat_t;

  proc_rec_t   loaded_set[$];
  sched_beat_t sched_q[$];
  string       field_name [NFIELDS] = '{"out_id", "out_arrival", "out_burst", "completion",
                                        "turnaround", "waiting", "avg_turnaround_q8",
                                        "avg_waiting_q8", "last_result"};

  // stable order by arrival then id, then walk the set in fcfs order
  task automatic schedule_set();
    proc_rec_t        key;
    sched_beat_t      b;
    bit [TIME_W-1:0]  run_comp;
    bit [TOTAL_W-1:0] tat_sum;
    bit [TOTAL_W-1:0] wt_sum;
    int               j;
    int               n;
    n = loaded_set.size();
    for (int i = 1; i < n; i++) begin
      key = loaded_set[i];
      j = i;
      while (j > 0 && (loaded_set[j-1].arr > key.arr ||
                       (loaded_set[j-1].arr == key.arr && loaded_set[j-1].id > key.id))) begin
        loaded_set[j] = loaded_set[j-1];
        j--;
      end
      loaded_set[j] = key;
    end
    run_comp = '0;
    tat_sum  = '0;
    wt_sum   = '0;
    foreach (loaded_set[k]) begin
      b.id   = loaded_set[k].id;
      b.arr  = loaded_set[k].arr;
      b.bur  = loaded_set[k].bur;
      b.comp = ((run_comp > TIME_W'(b.arr)) ? run_comp : TIME_W'(b.arr)) + TIME_W'(b.bur);
      b.tat  = b.comp - TIME_W'(b.arr);
      b.wt   = b.tat - TIME_W'(b.bur);
      run_comp = b.comp;
      tat_sum  = tat_sum + TOTAL_W'(b.tat);
      wt_sum   = wt_sum + TOTAL_W'(b.wt);
      b.last    = (k == n - 1);
      b.avg_tat = b.last ? AVG_W'((64'(tat_sum) << FRAC_W) / n) : '0;
      b.avg_wt  = b.last ? AVG_W'((64'(wt_sum) << FRAC_W) / n) : '0;
      sched_q.push_back(b);
    end
    loaded_set.delete();
  endtask

  task automatic check_beat();
    sched_beat_t     b;
    longint unsigned want [NFIELDS];
    longint unsigned got  [NFIELDS];
    bit              bad;
    got = '{out_tdata[FIELD_W-1:0], out_tdata[ARR_LSB +: FIELD_W],
            out_tdata[BUR_LSB +: FIELD_W], out_tdata[COMP_LSB +: TIME_W],
            out_tdata[TAT_LSB +: TIME_W], out_tdata[WT_LSB +: TIME_W],
            out_tdata[AVGT_LSB +: AVG_W], out_tdata[AVGW_LSB +: AVG_W], out_tlast};
    if (sched_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result beat with nothing scheduled, out_id %0d", $realtime, got[0]);
      return;
    end
    b = sched_q.pop_front();
    want = '{b.id, b.arr, b.bur, b.comp, b.tat, b.wt, b.avg_tat, b.avg_wt, b.last};
    bad = 1'b0;
    for (int f = 0; f < NFIELDS; f++) begin
      if (want[f] != got[f]) begin
        if (!bad) fail_count++;
        bad = 1'b1;
        if (fail_count <= 10)
          $display("%0t: %s expected %0d, got %0d", $realtime, field_name[f], want[f], got[f]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        loaded_set.push_back('{id: in_tdata[FIELD_W-1:0], arr: in_tdata[ARR_LSB +: FIELD_W],
                               bur: in_tdata[BUR_LSB +: FIELD_W]});
        // a full store ends the set whatever tlast says
        if (in_tlast || loaded_set.size() == MAX_PROCS) schedule_set();
      end
      if (out_tvalid && out_tready) check_beat();
      outstanding = sched_q.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// tb_top: stimulus, clock, reset and verdict for fcfs_schedule_timing_top
// depends on fcfs_pkg, fcfs_schedule_timing_top and fcfs_timing_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PROCS   = 32;
  localparam int          TARGET_PROCS = 120;  // stop opening new sets past this
  localparam int          STALL_LIMIT  = 3000; // cycles with no beat on either side
  localparam int          HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int          HOLD_AT_BEAT = 40;   // output beat count that triggers it

  logic                              clk;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [fcfs_pkg::IN_DATA_W-1:0]    in_tdata   = '0;   // proc_id, arrival, burst
  logic                              in_tlast   = 1'b0; // is_last
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  // out_id, out_arrival, out_burst, completion, turnaround, waiting,
  // avg_turnaround_q8, avg_waiting_q8, zero pad
  logic [fcfs_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                              out_tlast;         // last_result

  int fail_count;
  int outstanding;
  int procs_sent = 0;
  int rx_beats   = 0;
  bit fast_phase = 1'b0;  // both sides skip their gaps while set

  fcfs_schedule_timing_top #(.MAX_PROCS(MAX_PROCS)) DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  fcfs_timing_checker #(.MAX_PROCS(MAX_PROCS)) u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .fail_count, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one process beat after a random gap; valid stays up if the gap is zero
  task automatic send_proc(input bit [15:0] id, input bit [15:0] arr,
                           input bit [15:0] bur, input bit last);
    int gap;
    gap = fast_phase ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      // junk on the bus while valid is low, it must be ignored
      in_tvalid <= 1'b0;
      in_tdata  <= fcfs_pkg::IN_DATA_W'({$urandom(), $urandom()});
      in_tlast  <= 1'(($urandom_range(0, 1)));
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bur, arr, id};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    procs_sent++;
  endtask

  // one random set; narrow spans give ties on arrival and id, and long queues
  task automatic send_random_set(input int n);
    int   arr_span;
    int   id_span;
    int   bur_span;
    bit   last;
    arr_span = ($urandom_range(0, 2) == 0) ? 65535 : (($urandom_range(0, 1) == 0) ? 15 : 255);
    id_span  = ($urandom_range(0, 1) == 0) ? 65535 : 3;
    case ($urandom_range(0, 3))
      0:       bur_span = 0;
      1:       bur_span = 15;
      default: bur_span = 65535;
    endcase
    fast_phase = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      // only the final beat may carry tlast; a full set ends on the store
      // filling up, so its tlast bit is left to chance
      if (i != n - 1) last = 1'b0;
      else if (n == MAX_PROCS) last = 1'(($urandom_range(0, 1)));
      else last = 1'b1;
      send_proc(16'($urandom_range(0, id_span)), 16'($urandom_range(0, arr_span)),
                16'($urandom_range(0, bur_span)), last);
    end
  endtask

  // stimulus and verdict
  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero process on its own
    send_proc(16'h0000, 16'h0000, 16'h0000, 1'b1);
    // all-ones process on its own, largest completion of a single entry
    send_proc(16'hffff, 16'hffff, 16'hffff, 1'b1);
    // equal arrivals: order by id, duplicate ids keep their load order
    send_proc(16'd7,    16'd10, 16'd1, 1'b0);
    send_proc(16'd3,    16'd10, 16'd2, 1'b0);
    send_proc(16'd7,    16'd10, 16'd3, 1'b0);
    send_proc(16'd0,    16'd10, 16'd4, 1'b0);
    send_proc(16'hffff, 16'd10, 16'd5, 1'b1);
    // arrivals out of order, a zero burst and an idle gap before the last one
    send_proc(16'd1, 16'd100,   16'd5,     1'b0);
    send_proc(16'd2, 16'd0,     16'd10,    1'b0);
    send_proc(16'd3, 16'd5,     16'd0,     1'b0);
    send_proc(16'd4, 16'hffff,  16'hffff,  1'b1);

    // a full store whose final tlast is left to chance, then random sets
    send_random_set(MAX_PROCS);
    while (procs_sent < TARGET_PROCS) begin
      n = ($urandom_range(0, 7) == 0) ? MAX_PROCS : $urandom_range(1, 8);
      send_random_set(n);
    end
    in_tvalid <= 1'b0;
    fast_phase = 1'b0;

    // let the checker settle on the last input beat, then drain the schedule
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // receiver: random stalls per beat, and one long hold-off that backs the
  // block up until it drops in_tready while the sender keeps offering
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (rx_beats == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      else gap = fast_phase ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_beats++;
    end
  end

  // watchdog: ends the run when no beat moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
